[rtl/shfh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_pkg: shared types, constants and hash functions
// Command format between front and back, the queue sizing and the
// SuperFastHash round, tail and avalanche steps.
// ----------------------------------------------------------------------------
package shfh_pkg;

  // Command queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam logic [FIFO_CW-1:0] FIFO_FULL_CNT = FIFO_CW'(FIFO_DEPTH);

  // Work the back end applies to one beat
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FULL,
    OP_TAIL1,
    OP_TAIL2,
    OP_TAIL3
  } op_t;

  typedef struct packed {
    logic        seed;
    logic [30:0] seed_len;
    logic [31:0] word;
    op_t         op;
    logic        last;
  } cmd_t;

  // Sign-extend one byte
  function automatic logic [31:0] sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // Two-halfword mixing round for a full word
  function automatic logic [31:0] full_round(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] hh;
    logic [31:0] mix;
    hh  = h + {16'd0, w[15:0]};
    mix = {5'd0, w[31:16], 11'd0} ^ hh;
    hh  = (hh << 16) ^ mix;
    hh  = hh + (hh >> 11);
    return hh;
  endfunction

  // Leftover-byte rule for the last beat
  function automatic logic [31:0] tail_rule(input logic [31:0] h, input logic [31:0] w,
                                            input op_t op);
    logic [31:0] hh;
    logic [31:0] s;
    hh = h;
    s  = '0;
    case (op)
      OP_TAIL3: begin
        s  = sext8(w[23:16]);
        hh = h + {16'd0, w[15:0]};
        hh = hh ^ (hh << 16);
        hh = hh ^ (s << 18);
        hh = hh + (hh >> 11);
      end
      OP_TAIL2: begin
        hh = h + {16'd0, w[15:0]};
        hh = hh ^ (hh << 11);
        hh = hh + (hh >> 17);
      end
      OP_TAIL1: begin
        s  = sext8(w[7:0]);
        hh = h + s;
        hh = hh ^ (hh << 10);
        hh = hh + (hh >> 1);
      end
      default: hh = h;
    endcase
    return hh;
  endfunction

  // Avalanche, split in three pieces of one add each
  function automatic logic [31:0] aval_a(input logic [31:0] h);
    logic [31:0] hh;
    hh = h ^ (h << 3);
    hh = hh + (hh >> 5);
    return hh;
  endfunction

  function automatic logic [31:0] aval_b(input logic [31:0] h);
    logic [31:0] hh;
    hh = h ^ (h << 4);
    hh = hh + (hh >> 17);
    return hh;
  endfunction

  function automatic logic [31:0] aval_c(input logic [31:0] h);
    logic [31:0] hh;
    hh = h ^ (h << 25);
    hh = hh + (hh >> 6);
    return hh;
  endfunction

endpackage

[rtl/shfh_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_if: stream channels of the hash unit
// Word input channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface shfh_in_if;
  logic        valid;
  logic        ready;
  logic        first_word;
  logic [30:0] total_length;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;

  modport source (output valid, first_word, total_length, data_word, byte_count,
                  last_word, input ready);
  modport sink   (input valid, first_word, total_length, data_word, byte_count,
                  last_word, output ready);
endinterface

interface shfh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

[rtl/shfh_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_front: input beat classifier
// Tracks message framing, drops stray beats and turns each kept beat into
// a command for the back end.
// ----------------------------------------------------------------------------
module shfh_front
  import shfh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  shfh_in_if.sink in_bus,
  input  logic fifo_full,
  output logic push,
  output cmd_t cmd
);

  logic in_msg_r;
  logic in_msg_nxt;
  logic accept;
  op_t  op;

  assign in_bus.ready = !fifo_full;
  assign accept       = in_bus.valid && in_bus.ready;

  // Classify the beat: full word, tail of 1..3 bytes, or nothing
  always_comb begin
    op = OP_NONE;
    if (in_bus.byte_count[2]) begin
      op = OP_FULL;
    end else if (in_bus.last_word) begin
      case (in_bus.byte_count[1:0])
        2'd3:    op = OP_TAIL3;
        2'd2:    op = OP_TAIL2;
        2'd1:    op = OP_TAIL1;
        default: op = OP_NONE;
      endcase
    end
  end

  // Keep only beats that open or belong to a message
  assign push         = accept && (in_bus.first_word || in_msg_r);
  assign cmd.seed     = in_bus.first_word;
  assign cmd.seed_len = in_bus.total_length;
  assign cmd.word     = in_bus.data_word;
  assign cmd.op       = op;
  assign cmd.last     = in_bus.last_word;

  // Advance message framing
  always_comb begin
    in_msg_nxt = in_msg_r;
    if (accept) begin
      if (in_bus.first_word) begin
        in_msg_nxt = !in_bus.last_word;
      end else if (in_bus.last_word) begin
        in_msg_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

[rtl/shfh_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_fifo: command queue
// Small register queue that decouples the classifier from the hash core.
// ----------------------------------------------------------------------------
module shfh_fifo
  import shfh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_AW-1:0] wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == FIFO_FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

[rtl/shfh_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_back: hash core
// Pops one command per cycle if not stalled, runs the seed, mixing round or
// tail rule on the running hash, handing on a done message's pre-avalanche hash.
// ----------------------------------------------------------------------------
module shfh_back
  import shfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        empty,
  input  logic        adv,
  output logic        pop,
  output logic        res_vld,
  output logic [31:0] res_hash
);

  logic [31:0] run_hash_r;
  logic [31:0] run_hash_nxt;
  logic        res_vld_r;
  logic        res_vld_nxt;
  logic [31:0] res_hash_r;
  logic [31:0] base;
  logic [31:0] hash_new;

  assign pop = adv && !empty;

  // Pick the seed or the running hash, then apply this beat's work
  always_comb begin
    base = cmd.seed ? {1'b0, cmd.seed_len} : run_hash_r;
    case (cmd.op)
      OP_FULL:  hash_new = full_round(base, cmd.word);
      OP_TAIL1,
      OP_TAIL2,
      OP_TAIL3: hash_new = tail_rule(base, cmd.word, cmd.op);
      default:  hash_new = base;
    endcase
  end

  // Clear the running hash at end of message, else carry it
  always_comb begin
    run_hash_nxt = run_hash_r;
    res_vld_nxt  = res_vld_r;
    if (adv) begin
      res_vld_nxt = pop && cmd.last;
      if (pop) begin
        run_hash_nxt = cmd.last ? '0 : hash_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_hash_r <= '0;
      res_vld_r  <= 1'b0;
    end else begin
      run_hash_r <= run_hash_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // Hold the finished hash for the avalanche pipe
  always_ff @(posedge clk) begin
    if (adv) begin
      res_hash_r <= hash_new;
    end
  end

  assign res_vld  = res_vld_r;
  assign res_hash = res_hash_r;

endmodule

[rtl/shfh_aval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_aval: avalanche pipeline
// Three stages of the final avalanche, the last one being the output
// register of the result channel. The whole pipe stalls as one.
// ----------------------------------------------------------------------------
module shfh_aval
  import shfh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_hash,
  output logic        adv,
  shfh_out_if.source  out_bus
);

  logic        a_vld_r;
  logic        b_vld_r;
  logic        o_vld_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] o_r;

  // Advance unless a finished beat waits on the result side
  assign adv = !o_vld_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      o_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= aval_a(in_hash);
      b_r <= aval_b(a_r);
      o_r <= aval_c(b_r);
    end
  end

  assign out_bus.valid      = o_vld_r;
  assign out_bus.hash_value = o_r;

endmodule

[rtl/superfast_hash_stream_unit.sv]
`timescale 1ns / 1ps
// Path: a last beat's hash passes through the command queue, the hash core
// register, two avalanche stages and the output register.
// Throughput: one beat per cycle if the queue has room; the core's running-hash
// loop does one word round per cycle; the queue takes beats while results wait.
// Reset: synchronous, active low; clears the queue, framing, running hash and
// all valid flags.
// ----------------------------------------------------------------------------
// superfast_hash_stream_unit: streaming 32-bit SuperFastHash
// Hashes a byte message delivered as little-endian 32-bit word beats and
// emits one hash per message.
// ----------------------------------------------------------------------------
module superfast_hash_stream_unit
  import shfh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  shfh_in_if.sink    in_bus,
  shfh_out_if.source out_bus
);

  cmd_t        wr_cmd;
  cmd_t        rd_cmd;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic        adv;
  logic        res_vld;
  logic [31:0] res_hash;

  shfh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .fifo_full (full),
    .push      (push),
    .cmd       (wr_cmd)
  );

  shfh_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (full),
    .empty  (empty)
  );

  shfh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rd_cmd),
    .empty    (empty),
    .adv      (adv),
    .pop      (pop),
    .res_vld  (res_vld),
    .res_hash (res_hash)
  );

  shfh_aval u_aval (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (res_vld),
    .in_hash (res_hash),
    .adv     (adv),
    .out_bus (out_bus)
  );

endmodule

[rtl/shfh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfh_checker: port-level checks of the hash unit
// Tracks message framing and the number of messages owed a result, and
// checks the result channel against it.
// ----------------------------------------------------------------------------
module shfh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_first,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);

  logic       in_msg_r;
  logic [3:0] pend_r;
  logic       in_acc;
  logic       last_acc;
  logic       out_acc;

  assign in_acc   = in_valid && in_ready;
  assign last_acc = in_acc && in_last && (in_first || in_msg_r);
  assign out_acc  = out_valid && out_ready;

  // Mirror framing and count messages still owed a hash
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      pend_r   <= '0;
    end else begin
      if (in_acc) begin
        if (in_first) begin
          in_msg_r <= !in_last;
        end else if (in_last) begin
          in_msg_r <= 1'b0;
        end
      end
      pend_r <= pend_r + {3'd0, last_acc} - {3'd0, out_acc};
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("result beat dropped or changed while stalled");

  // No result without a finished message behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result beat without a finished message");

  // Owed results never exceed what queue and pipe can hold
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd8)
    else $error("more messages in flight than storage allows");

  // Reset leaves the result channel empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind superfast_hash_stream_unit shfh_checker u_shfh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_first  (in_bus.first_word),
  .in_last   (in_bus.last_word),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_hash  (out_bus.hash_value)
);
